/* rtl/ght_pkg.sv */
// Package for the generation checked handle table.
// Holds sizes, limits, request and status codes, and the controller/datapath structs.
// No dependencies.
package ght_pkg;

  // Table size and derived index widths
  localparam int unsigned SLOT_COUNT = 16;
  localparam int unsigned SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W      = $clog2(SLOT_COUNT + 1);

  // Limits, capped at the 16-bit storage width
  localparam longint unsigned GENERATION_LIMIT = 65535;
  localparam longint unsigned COUNT_LIMIT      = 65535;
  localparam logic [15:0] GEN_LIMIT =
      16'((GENERATION_LIMIT > 65535) ? 65535 : GENERATION_LIMIT);
  localparam logic [15:0] CNT_LIMIT =
      16'((COUNT_LIMIT > 65535) ? 65535 : COUNT_LIMIT);

  // Request kinds (codes 5..7 are unused)
  localparam logic [2:0] KIND_MAIN_CREATE = 3'd0;
  localparam logic [2:0] KIND_MAIN_DESTROY = 3'd1;
  localparam logic [2:0] KIND_CTX_CREATE  = 3'd2;
  localparam logic [2:0] KIND_CTX_DESTROY = 3'd3;
  localparam logic [2:0] KIND_VALIDATE    = 3'd4;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_INIT = 2'd1,
    ST_INVALID  = 2'd2,
    ST_ERROR    = 2'd3
  } status_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    load;       // latch request fields
    logic    rd_en;      // read table entry
    logic    rd_scan;    // read address is the scan counter, else request slot
    logic    scan_clr;   // restart the free-slot scan
    logic    main_inc;
    logic    main_dec;
    logic    ctx_inc;
    logic    ctx_dec;
    logic    alloc;      // claim the slot just read
    logic    free_slot;  // release the request slot
    logic    finish;     // register the result
    status_t status;
  } ght_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [2:0] kind;
    logic       hnull;
    logic       need;
    logic       slot_ok;
    logic       main_zero;
    logic       main_full;
    logic       ctx_zero;
    logic       ctx_full;
    logic       scan_more;
    logic       rd_valid;
    logic       rd_free;
    logic       rd_match;
    logic       rd_last;
  } ght_stat_t;

endpackage

/* rtl/ght_datapath.sv */
// Datapath of the generation checked handle table: request latch, counts,
// slot table (active flops plus generation memory) and result registers.
// Depends on ght_pkg.
module ght_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        kind,
  input  logic [3:0]        handle_slot,
  input  logic [15:0]       handle_generation,
  input  logic              handle_null,
  input  logic              need_context,
  input  ght_pkg::ght_cmd_t cmd,
  output ght_pkg::ght_stat_t stat,
  output logic              done,
  output logic [1:0]        status,
  output logic [3:0]        new_slot,
  output logic [15:0]       new_generation
);
  import ght_pkg::*;

  // Latched request
  logic [2:0]        req_kind;
  logic [3:0]        req_slot;
  logic [15:0]       req_gen;
  logic              req_null;
  logic              req_need;

  // Counts and table
  logic [15:0]           main_count;
  logic [15:0]           ctx_count;
  logic [SLOT_COUNT-1:0] slot_active;
  logic [SLOT_COUNT-1:0] gen_written;
  logic [15:0]           gen_mem [SLOT_COUNT];

  // Scan counter and read port
  logic [CNT_W-1:0]  scan_cnt;
  logic [SLOT_W-1:0] rd_addr;
  logic [SLOT_W-1:0] req_idx;
  logic [SLOT_W-1:0] rd_idx;
  logic [15:0]       rd_mem;
  logic              rd_wr;
  logic              rd_act;
  logic              rd_valid;
  logic [15:0]       rd_gen;

  assign req_idx = SLOT_W'(req_slot);
  assign rd_addr = cmd.rd_scan ? scan_cnt[SLOT_W-1:0] : req_idx;
  // never-written entries read as generation zero
  assign rd_gen  = rd_wr ? rd_mem : 16'd0;

  // Request latch
  always_ff @(posedge clk) begin
    if (start && cmd.load) begin
      req_kind <= kind;
      req_slot <= handle_slot;
      req_gen  <= handle_generation;
      req_null <= handle_null;
      req_need <= need_context;
    end
  end

  // Generation memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      gen_mem[rd_idx] <= rd_gen + 16'd1;
    end
    if (cmd.rd_en) begin
      rd_mem <= gen_mem[rd_addr];
      rd_idx <= rd_addr;
    end
  end

  // Control state: table flags, counts, scan, read valid
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
      gen_written <= '0;
      main_count  <= '0;
      ctx_count   <= '0;
      scan_cnt    <= '0;
      rd_valid    <= 1'b0;
      rd_wr       <= 1'b0;
      rd_act      <= 1'b0;
    end else begin
      rd_valid <= cmd.rd_en;
      if (cmd.rd_en) begin
        rd_wr  <= gen_written[rd_addr];
        rd_act <= slot_active[rd_addr];
      end
      if (cmd.alloc) begin
        slot_active[rd_idx] <= 1'b1;
        gen_written[rd_idx] <= 1'b1;
      end
      if (cmd.free_slot) begin
        slot_active[req_idx] <= 1'b0;
      end
      if (cmd.main_inc) begin
        main_count <= main_count + 16'd1;
      end else if (cmd.main_dec) begin
        main_count <= main_count - 16'd1;
      end
      if (cmd.ctx_inc) begin
        ctx_count <= ctx_count + 16'd1;
      end else if (cmd.ctx_dec) begin
        ctx_count <= ctx_count - 16'd1;
      end
      if (cmd.scan_clr) begin
        scan_cnt <= '0;
      end else if (cmd.rd_en && cmd.rd_scan) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end
    end
  end

  // Result registers; done is a one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status         <= cmd.status;
      new_slot       <= cmd.alloc ? 4'(rd_idx) : 4'd0;
      new_generation <= cmd.alloc ? rd_gen + 16'd1 : 16'd0;
    end
  end

  // Status to controller
  always_comb begin
    stat.kind      = req_kind;
    stat.hnull     = req_null;
    stat.need      = req_need;
    stat.slot_ok   = !req_null && (32'(req_slot) < 32'(SLOT_COUNT));
    stat.main_zero = (main_count == 16'd0);
    stat.main_full = (main_count >= CNT_LIMIT);
    stat.ctx_zero  = (ctx_count == 16'd0);
    stat.ctx_full  = (ctx_count >= CNT_LIMIT);
    stat.scan_more = (scan_cnt < CNT_W'(SLOT_COUNT));
    stat.rd_valid  = rd_valid;
    stat.rd_free   = !rd_act && (rd_gen < GEN_LIMIT);
    stat.rd_match  = rd_act && (rd_gen == req_gen);
    stat.rd_last   = (rd_idx == SLOT_W'(SLOT_COUNT - 1));
  end

  // A slot is claimed only right after a read that found it free
  a_alloc_free: assert property (@(posedge clk) disable iff (rst)
      cmd.alloc |-> (rd_valid && !rd_act && rd_gen < GEN_LIMIT))
    else $error("slot claimed without a free entry read");

  // A failed transaction carries no handle
  a_no_handle_on_fail: assert property (@(posedge clk) disable iff (rst)
      (done && status != ST_OK) |-> (new_slot == 4'd0 && new_generation == 16'd0))
    else $error("handle reported on a failed transaction");

  // Main count moves by at most one per cycle
  a_main_step: assert property (@(posedge clk) disable iff (rst)
      !$past(rst) |-> (main_count == $past(main_count) ||
                       main_count == $past(main_count) + 16'd1 ||
                       main_count == $past(main_count) - 16'd1))
    else $error("main count jumped");

  // Context count moves only with a finished transaction
  a_ctx_step: assert property (@(posedge clk) disable iff (rst)
      (cmd.ctx_inc || cmd.ctx_dec) |-> cmd.finish)
    else $error("context count changed outside a result");

endmodule

/* rtl/ght_ctrl.sv */
// Controller of the generation checked handle table: sequences each request
// (decide, table read and check, or free-slot scan) and issues datapath commands.
// Depends on ght_pkg.
module ght_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ght_pkg::ght_stat_t stat,
  output ght_pkg::ght_cmd_t  cmd,
  output logic               busy
);
  import ght_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CHECK,
    S_SCAN
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.status = ST_ERROR;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
        case (stat.kind)
          KIND_MAIN_CREATE: begin
            cmd.finish = 1'b1;
            if (!stat.main_full) begin
              cmd.main_inc = 1'b1;
              cmd.status   = ST_OK;
            end
          end
          KIND_MAIN_DESTROY: begin
            cmd.finish = 1'b1;
            if (!stat.main_zero) begin
              cmd.main_dec = 1'b1;
              cmd.status   = ST_OK;
            end else begin
              cmd.status = ST_NOT_INIT;
            end
          end
          KIND_CTX_CREATE: begin
            if (stat.ctx_full) begin
              cmd.finish = 1'b1;
            end else begin
              cmd.scan_clr = 1'b1;
              state_next   = S_SCAN;
            end
          end
          KIND_CTX_DESTROY: begin
            if (!stat.slot_ok) begin
              cmd.finish = 1'b1;
              cmd.status = ST_INVALID;
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_CHECK;
            end
          end
          KIND_VALIDATE: begin
            if (stat.main_zero && stat.ctx_zero) begin
              cmd.finish = 1'b1;
              cmd.status = ST_NOT_INIT;
            end else if (!stat.need) begin
              cmd.finish = 1'b1;
              cmd.status = ST_OK;
            end else if (stat.hnull) begin
              cmd.finish = 1'b1;
              cmd.status = stat.main_zero ? ST_INVALID : ST_OK;
            end else if (!stat.slot_ok) begin
              cmd.finish = 1'b1;
              cmd.status = ST_INVALID;
            end else begin
              cmd.rd_en  = 1'b1;
              state_next = S_CHECK;
            end
          end
          default: begin
            cmd.finish = 1'b1;
          end
        endcase
      end
      S_CHECK: begin
        // entry of the presented slot is in the read registers
        state_next = S_IDLE;
        cmd.finish = 1'b1;
        if (!stat.rd_match) begin
          cmd.status = ST_INVALID;
        end else if (stat.kind == KIND_CTX_DESTROY) begin
          cmd.free_slot = 1'b1;
          if (stat.ctx_zero) begin
            cmd.status = ST_NOT_INIT;
          end else begin
            cmd.ctx_dec = 1'b1;
            cmd.status  = ST_OK;
          end
        end else begin
          cmd.status = ST_OK;
        end
      end
      S_SCAN: begin
        // one read issued and one entry checked per cycle
        cmd.rd_scan = 1'b1;
        cmd.rd_en   = stat.scan_more;
        if (stat.rd_valid && stat.rd_free) begin
          cmd.rd_en   = 1'b0;
          cmd.alloc   = 1'b1;
          cmd.ctx_inc = 1'b1;
          cmd.finish  = 1'b1;
          cmd.status  = ST_OK;
          state_next  = S_IDLE;
        end else if (stat.rd_valid && stat.rd_last) begin
          cmd.finish = 1'b1;
          cmd.status = ST_ERROR;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // A result is produced only by a busy controller
  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
      cmd.finish |-> busy)
    else $error("result produced while idle");

  // Every finished transaction returns to idle
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
      cmd.finish |=> !busy)
    else $error("controller stayed busy after a result");

  // Scan reads never run past the table
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
      (cmd.rd_en && cmd.rd_scan) |-> stat.scan_more)
    else $error("scan read beyond last slot");

endmodule

/* rtl/generation_checked_handle_table_unit.sv */
// Generation checked handle table: 16 context slots with active bits and generation
// counts, plus main and context reference counts. Top level; depends on ght_pkg,
// ght_ctrl and ght_datapath.
//
// A request is taken when start is high and busy is low; its result appears on
// status/new_slot/new_generation for exactly one cycle with done high and cannot be
// stalled. Main create/destroy, and any request settled without a table lookup,
// give done from the decide step; context destroy and validate with a handle
// lookup first read and check the slot entry. Context create scans the table
// from slot 0, one slot per cycle through the single read port of the generation
// memory, and claims the first free slot; a full table reports an error. busy drops
// in the cycle done rises, so the next request may be given while the previous
// result is shown. No clearing pass after reset.
module generation_checked_handle_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind,
  input  logic [3:0]  handle_slot,
  input  logic [15:0] handle_generation,
  input  logic        handle_null,
  input  logic        need_context,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  new_slot,
  output logic [15:0] new_generation
);
  import ght_pkg::*;

  ght_cmd_t  cmd;
  ght_stat_t stat;

  // Sequencer
  ght_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  // Table, counts and result registers
  ght_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .kind             (kind),
    .handle_slot      (handle_slot),
    .handle_generation(handle_generation),
    .handle_null      (handle_null),
    .need_context     (need_context),
    .cmd              (cmd),
    .stat             (stat),
    .done             (done),
    .status           (status),
    .new_slot         (new_slot),
    .new_generation   (new_generation)
  );

endmodule

/* tb/generation_checked_handle_table_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for generation_checked_handle_table_unit: directed, random and
// saturation traffic, checked against a scoreboard that tracks slots and reference counts.
// Depends on ght_pkg and the unit's RTL.
module generation_checked_handle_table_unit_tb;
  import ght_pkg::*;

  localparam int unsigned     DRAIN_CYCLES   = SLOT_COUNT + 8;
  localparam longint unsigned CYCLE_LIMIT    = 64'd400_000;
  localparam int unsigned     RANDOM_ITEMS   = 1690;
  localparam int unsigned     MAX_PRINTED    = 100;
  // Request codes with no function in the unit
  localparam logic [2:0]      KIND_SPARE_FIRST = 3'd5;
  localparam logic [2:0]      KIND_SPARE_LAST  = 3'd7;

  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic [15:0] generation;
  } table_answer_t;

  // Scoreboard: mirrors the handle table and queues the answer of each transaction
  class handle_table_scoreboard;
    bit            slot_active [SLOT_COUNT];
    logic [15:0]   slot_gen [SLOT_COUNT];
    int unsigned   main_refs;
    int unsigned   ctx_refs;
    table_answer_t expected_answers [$];
    int unsigned   mismatches;

    function new();
      foreach (slot_active[i]) begin
        slot_active[i] = 1'b0;
        slot_gen[i]    = 16'd0;
      end
      main_refs  = 0;
      ctx_refs   = 0;
      mismatches = 0;
    endfunction

    // Handle names an active slot whose generation matches
    function bit handle_live(logic [3:0] hslot, logic [15:0] hgen, logic hnull);
      if (hnull || hslot >= SLOT_COUNT) return 1'b0;
      return slot_active[hslot] && slot_gen[hslot] == hgen;
    endfunction

    // Accepted transaction: update the table copy and queue its answer
    function void take_request(logic [2:0] kind, logic [3:0] hslot, logic [15:0] hgen,
                               logic hnull, logic need);
      table_answer_t ans;
      int            i;
      ans.status     = ST_ERROR;
      ans.slot       = 4'd0;
      ans.generation = 16'd0;
      case (kind)
        KIND_MAIN_CREATE: begin
          if (main_refs < CNT_LIMIT) begin
            main_refs++;
            ans.status = ST_OK;
          end
        end
        KIND_MAIN_DESTROY: begin
          if (main_refs > 0) begin
            main_refs--;
            ans.status = ST_OK;
          end else begin
            ans.status = ST_NOT_INIT;
          end
        end
        KIND_CTX_CREATE: begin
          // lowest free slot that is not retired
          if (ctx_refs < CNT_LIMIT) begin
            for (i = 0; i < SLOT_COUNT; i++) begin
              if (!slot_active[i] && slot_gen[i] < GEN_LIMIT) begin
                slot_gen[i]    = slot_gen[i] + 16'd1;
                slot_active[i] = 1'b1;
                ctx_refs++;
                ans.status     = ST_OK;
                ans.slot       = 4'(i);
                ans.generation = slot_gen[i];
                break;
              end
            end
          end
        end
        KIND_CTX_DESTROY: begin
          if (!handle_live(hslot, hgen, hnull)) begin
            ans.status = ST_INVALID;
          end else begin
            slot_active[hslot] = 1'b0;
            if (ctx_refs > 0) begin
              ctx_refs--;
              ans.status = ST_OK;
            end else begin
              ans.status = ST_NOT_INIT;
            end
          end
        end
        KIND_VALIDATE: begin
          if (main_refs == 0 && ctx_refs == 0) begin
            ans.status = ST_NOT_INIT;
          end else if (need) begin
            ans.status = (hnull ? (main_refs > 0) : handle_live(hslot, hgen, hnull)) ?
                         ST_OK : ST_INVALID;
          end else begin
            ans.status = ST_OK;
          end
        end
        default: ;
      endcase
      expected_answers.push_back(ans);
    endfunction

    task report_mismatch(string what, logic [15:0] want, logic [15:0] got);
      if (mismatches < MAX_PRINTED)
        $display("%0t: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
      mismatches++;
    endtask

    // Compare one result with the oldest queued answer
    task check_result(logic [1:0] st, logic [3:0] nslot, logic [15:0] ngen);
      table_answer_t want;
      if (expected_answers.size() == 0) begin
        report_mismatch("result with nothing pending, status", 16'd0, 16'(st));
        return;
      end
      want = expected_answers.pop_front();
      if (st !== want.status) report_mismatch("status", 16'(want.status), 16'(st));
      if (nslot !== want.slot) report_mismatch("new_slot", 16'(want.slot), 16'(nslot));
      if (ngen !== want.generation) report_mismatch("new_generation", want.generation, ngen);
    endtask
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  kind = '0;
  logic [3:0]  handle_slot = '0;
  logic [15:0] handle_generation = '0;
  logic        handle_null = 1'b0;
  logic        need_context = 1'b0;
  logic        done;
  logic [1:0]  status;
  logic [3:0]  new_slot;
  logic [15:0] new_generation;

  handle_table_scoreboard sb = new();
  longint unsigned        cycles = 0;
  bit                     calm = 1'b0;

  generation_checked_handle_table_unit i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .kind             (kind),
    .handle_slot      (handle_slot),
    .handle_generation(handle_generation),
    .handle_null      (handle_null),
    .need_context     (need_context),
    .done             (done),
    .status           (status),
    .new_slot         (new_slot),
    .new_generation   (new_generation)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("generation_checked_handle_table_unit_tb: FAIL");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check_result(status, new_slot, new_generation);
  end

  // Present one transaction and hold it until the unit takes it
  task automatic send(input logic [2:0] k, input logic [3:0] s, input logic [15:0] g,
                      input logic n, input logic nd);
    start             <= 1'b1;
    kind              <= k;
    handle_slot       <= s;
    handle_generation <= g;
    handle_null       <= n;
    need_context      <= nd;
    do @(posedge clk); while (busy !== 1'b0);
    sb.take_request(k, s, g, n, nd);
  endtask

  // Random idle gap between transactions, mostly short
  task automatic pause();
    int unsigned r;
    int unsigned gap;
    r = $urandom_range(0, 99);
    if (calm || r < 45) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop sending until every pending answer has come back
  task automatic drain();
    start <= 1'b0;
    while (sb.expected_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One random transaction, mostly built from handles that are live or nearly so
  task automatic random_item();
    int unsigned r;
    logic [3:0]  live [$];
    logic [3:0]  pick;
    logic [3:0]  rs;
    logic [15:0] rg;
    logic [15:0] g;
    logic        rn;
    logic        rd;
    foreach (sb.slot_active[i]) if (sb.slot_active[i]) live.push_back(4'(i));
    rs = 4'($urandom_range(0, 15));
    rg = 16'($urandom);
    rn = 1'($urandom);
    rd = 1'($urandom);
    pick = (live.size() > 0) ? live[$urandom_range(0, live.size() - 1)] : rs;
    case ($urandom_range(0, 3))
      0:       g = sb.slot_gen[rs] - 16'd1;
      1:       g = sb.slot_gen[rs] + 16'd1;
      2:       g = sb.slot_gen[rs];
      default: g = rg;
    endcase
    r = $urandom_range(0, 99);
    if (r < 22) send(KIND_CTX_CREATE, rs, rg, rn, rd);
    else if (r < 40 && live.size() > 0)
      send(KIND_CTX_DESTROY, pick, sb.slot_gen[pick], 1'b0, rd);
    else if (r < 48) send(KIND_CTX_DESTROY, rs, g, $urandom_range(0, 9) == 0, rd);
    else if (r < 62 && live.size() > 0)
      send(KIND_VALIDATE, pick, sb.slot_gen[pick], 1'b0, $urandom_range(0, 4) != 0);
    else if (r < 70) send(KIND_VALIDATE, rs, r[0] ? g : rg, rn, rd);
    else if (r < 80) send(KIND_MAIN_CREATE, rs, rg, rn, rd);
    else if (r < 90) send(KIND_MAIN_DESTROY, rs, rg, rn, rd);
    else if (r < 95) send(3'($urandom), rs, rg, rn, rd);
    else send(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)), rs, rg, rn, rd);
  endtask

  // Stimulus
  initial begin
    int unsigned n;
    logic [2:0]  k;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: not ready, bad handles, null handles, first allocations
    send(KIND_VALIDATE, 4'd0, 16'd0, 1'b1, 1'b0);
    send(KIND_VALIDATE, 4'd15, 16'hFFFF, 1'b0, 1'b1);
    send(KIND_MAIN_DESTROY, 4'd0, 16'd0, 1'b0, 1'b0);
    send(KIND_CTX_DESTROY, 4'd0, 16'd0, 1'b1, 1'b0);
    send(KIND_MAIN_CREATE, 4'd15, 16'hFFFF, 1'b1, 1'b1);
    send(KIND_VALIDATE, 4'd0, 16'd0, 1'b1, 1'b1);
    send(KIND_VALIDATE, 4'd15, 16'hFFFF, 1'b0, 1'b0);
    send(KIND_VALIDATE, 4'd15, 16'hFFFF, 1'b0, 1'b1);
    send(KIND_CTX_CREATE, 4'd0, 16'd0, 1'b0, 1'b0);
    send(KIND_CTX_CREATE, 4'd15, 16'hFFFF, 1'b1, 1'b1);
    send(KIND_VALIDATE, 4'd1, 16'd1, 1'b0, 1'b1);
    send(KIND_VALIDATE, 4'd0, 16'd0, 1'b0, 1'b1);
    send(KIND_CTX_DESTROY, 4'd0, 16'hFFFF, 1'b0, 1'b0);
    send(KIND_MAIN_DESTROY, 4'd0, 16'd0, 1'b0, 1'b0);
    send(KIND_VALIDATE, 4'd0, 16'd0, 1'b1, 1'b1);
    send(KIND_CTX_DESTROY, 4'd0, 16'd1, 1'b0, 1'b1);
    send(KIND_CTX_DESTROY, 4'd0, 16'd1, 1'b0, 1'b0);
    send(KIND_CTX_CREATE, 4'd0, 16'd0, 1'b0, 1'b0);
    for (k = KIND_SPARE_FIRST; k != KIND_SPARE_LAST; k++)
      send(k, 4'd15, 16'hFFFF, 1'b1, 1'b1);
    send(KIND_SPARE_LAST, 4'd0, 16'd0, 1'b0, 1'b0);
    drain();

    // random traffic, with gap-free stretches and one full drain halfway
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm = ((n / 150) % 3) == 2;
      if (n == RANDOM_ITEMS / 2) drain();
      random_item();
      pause();
    end
    calm = 1'b1;
    drain();

    // free every slot, then fill the table until it reports full
    foreach (sb.slot_active[i])
      if (sb.slot_active[i]) send(KIND_CTX_DESTROY, 4'(i), sb.slot_gen[i], 1'b0, 1'b0);
    for (n = 0; n <= SLOT_COUNT; n++) send(KIND_CTX_CREATE, 4'd0, 16'd0, 1'b0, 1'b0);
    send(KIND_VALIDATE, 4'd0, sb.slot_gen[0], 1'b0, 1'b1);
    send(KIND_CTX_DESTROY, 4'd0, sb.slot_gen[0] + 16'd1, 1'b0, 1'b0);
    send(KIND_CTX_DESTROY, 4'd15, sb.slot_gen[15], 1'b0, 1'b0);
    send(KIND_CTX_CREATE, 4'd0, 16'd0, 1'b0, 1'b0);

    // main count up and down around the null-handle checks
    send(KIND_MAIN_CREATE, 4'd0, 16'd0, 1'b0, 1'b0);
    send(KIND_MAIN_CREATE, 4'd15, 16'hFFFF, 1'b1, 1'b1);
    send(KIND_VALIDATE, 4'd0, 16'd0, 1'b1, 1'b1);
    send(KIND_MAIN_DESTROY, 4'd0, 16'd0, 1'b0, 1'b0);
    send(KIND_MAIN_CREATE, 4'd0, 16'd0, 1'b0, 1'b0);
    send(KIND_MAIN_CREATE, 4'd0, 16'd0, 1'b0, 1'b0);
    drain();

    if (sb.mismatches == 0 && sb.expected_answers.size() == 0) begin
      $display("generation_checked_handle_table_unit_tb: PASS");
    end else begin
      $display("generation_checked_handle_table_unit_tb: FAIL");
    end
    $finish;
  end
endmodule
